// ===== rtl/pfc_pkg.sv =====
// Shared types, constants and helper functions for the Playfair digraph cipher.
// Depends on nothing; included first in compilation order.
package pfc_pkg;

  localparam int GRID_SIDE  = 5;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int LETTER_W   = 5;
  localparam int CELL_IDX_W = $clog2(GRID_CELLS);
  localparam int COORD_W    = 3;
  localparam int REG_W      = 60;
  localparam int LOW_CELLS  = 12;

  localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
  localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [1:0] REG_CELLS_LOW = 2'd0;
  localparam logic [1:0] REG_CELLS_MID = 2'd1;
  localparam logic [1:0] REG_CELL_LAST = 2'd2;

  localparam logic [COORD_W-1:0] COORD_LAST = COORD_W'(GRID_SIDE - 1);

  typedef struct packed {
    logic                operation;
    logic [LETTER_W-1:0] letter_first;
    logic [LETTER_W-1:0] letter_second;
  } pair_req_t;

  typedef struct packed {
    logic [LETTER_W-1:0] result_first;
    logic [LETTER_W-1:0] result_second;
    logic                filler_used;
  } pair_rsp_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } grid_pos_t;

  // First matching cell in row-major order; no match gives row 0, column 0.
  function automatic grid_pos_t lowest_hit(input logic [GRID_CELLS-1:0] hits);
    grid_pos_t pos;
    pos = '0;
    for (int r = GRID_SIDE - 1; r >= 0; r--) begin
      for (int c = GRID_SIDE - 1; c >= 0; c--) begin
        if (hits[r * GRID_SIDE + c]) begin
          pos.row = COORD_W'(r);
          pos.col = COORD_W'(c);
        end
      end
    end
    return pos;
  endfunction

  // One step along a row or column with wrap-around; backwards on decrypt.
  function automatic logic [COORD_W-1:0] wrap_step(input logic [COORD_W-1:0] v,
                                                   input logic backwards);
    logic [COORD_W-1:0] r;
    if (backwards) begin
      r = (v == '0) ? COORD_LAST : v - COORD_W'(1);
    end else begin
      r = (v == COORD_LAST) ? '0 : v + COORD_W'(1);
    end
    return r;
  endfunction

  // Row-major cell index of a grid position.
  function automatic logic [CELL_IDX_W-1:0] cell_index(input grid_pos_t pos);
    return CELL_IDX_W'(pos.row * GRID_SIDE + pos.col);
  endfunction

endpackage

// ===== rtl/playfair_digraph_cipher.sv =====
// Top level of the Playfair digraph cipher: key square registers and a three-stage pipeline.
// Depends on pfc_pkg for the transaction structs, constants and helper functions.
//
// Each request transaction carries one letter pair and an encrypt or decrypt selector; each
// yields exactly one response transaction with the transformed pair and a flag that is set when
// an encrypted doubled pair had its second letter replaced by x. Letter j is treated as i. The
// 5x5 key square is loaded through the write port as three registers (cells 0 to 11, cells 12
// to 23, and cell 24, five bits per cell in row-major order) and must only be written while no
// transaction is in flight. The pipeline has three register stages: letter compare against all
// 25 cells, position encoding, then rule selection and cell look-up into the response register.
// A response is presented from the response register once its request has passed the compare
// and encode stages, and a new pair can be accepted on every clock cycle while req_stall is low;
// the request stall is only raised when all three stages are full and the response side is stalling.
module playfair_digraph_cipher (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [pfc_pkg::REG_W-1:0] cfg_data,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  pfc_pkg::pair_req_t      req,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output pfc_pkg::pair_rsp_t      rsp
);

  // Key square registers, as written by software.
  logic [pfc_pkg::REG_W-1:0]    sq_low;
  logic [pfc_pkg::REG_W-1:0]    sq_mid;
  logic [pfc_pkg::LETTER_W-1:0] sq_last;

  logic [pfc_pkg::LETTER_W-1:0] cells [pfc_pkg::GRID_CELLS];

  // Stage 1: match vectors. Stage 2: grid positions. Stage 3: the response register.
  logic                           v1, v2, v3;
  logic                           op1, op2;
  logic                           fill1, fill2;
  logic [pfc_pkg::GRID_CELLS-1:0] hits_a1, hits_b1;
  pfc_pkg::grid_pos_t             pos_a2, pos_b2;

  logic rdy1, rdy2, rdy3;

  logic [pfc_pkg::LETTER_W-1:0]   let_a, let_b, let_b_fixed;
  logic                           filler;
  logic [pfc_pkg::GRID_CELLS-1:0] hits_a, hits_b;

  pfc_pkg::grid_pos_t             tgt_a, tgt_b;
  logic [pfc_pkg::CELL_IDX_W-1:0] idx_a, idx_b;
  pfc_pkg::pair_rsp_t             rsp_next;

  // A stage may take new contents when it is empty or its contents move on this cycle.
  assign rdy3      = !v3 || !rsp_stall;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign req_stall = !rdy1;
  assign rsp_valid = v3;

  // Configuration writes. An index with no register behind it is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_low  <= '0;
      sq_mid  <= '0;
      sq_last <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        pfc_pkg::REG_CELLS_LOW: sq_low  <= cfg_data;
        pfc_pkg::REG_CELLS_MID: sq_mid  <= cfg_data;
        pfc_pkg::REG_CELL_LAST: sq_last <= cfg_data[pfc_pkg::LETTER_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the square into one letter per cell.
  always_comb begin
    for (int k = 0; k < pfc_pkg::LOW_CELLS; k++) begin
      cells[k]                     = sq_low[k*pfc_pkg::LETTER_W +: pfc_pkg::LETTER_W];
      cells[k + pfc_pkg::LOW_CELLS] = sq_mid[k*pfc_pkg::LETTER_W +: pfc_pkg::LETTER_W];
    end
    cells[pfc_pkg::GRID_CELLS-1] = sq_last;
  end

  // Stage 1 logic: fold j onto i, insert the x filler for a doubled pair on encryption, then
  // compare both letters against every cell of the square in parallel.
  always_comb begin
    let_a       = (req.letter_first  == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : req.letter_first;
    let_b       = (req.letter_second == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : req.letter_second;
    filler      = (req.operation == pfc_pkg::OP_ENCRYPT) && (let_a == let_b);
    let_b_fixed = filler ? pfc_pkg::LETTER_X : let_b;
    for (int k = 0; k < pfc_pkg::GRID_CELLS; k++) begin
      hits_a[k] = (cells[k] == let_a);
      hits_b[k] = (cells[k] == let_b_fixed);
    end
  end

  // Stage 3 logic: apply the same-row, same-column or rectangle rule, then read the cells.
  always_comb begin
    if (pos_a2.row == pos_b2.row) begin
      tgt_a = '{row: pos_a2.row, col: pfc_pkg::wrap_step(pos_a2.col, op2)};
      tgt_b = '{row: pos_b2.row, col: pfc_pkg::wrap_step(pos_b2.col, op2)};
    end else if (pos_a2.col == pos_b2.col) begin
      tgt_a = '{row: pfc_pkg::wrap_step(pos_a2.row, op2), col: pos_a2.col};
      tgt_b = '{row: pfc_pkg::wrap_step(pos_b2.row, op2), col: pos_b2.col};
    end else begin
      tgt_a = '{row: pos_a2.row, col: pos_b2.col};
      tgt_b = '{row: pos_b2.row, col: pos_a2.col};
    end
    idx_a                  = pfc_pkg::cell_index(tgt_a);
    idx_b                  = pfc_pkg::cell_index(tgt_b);
    rsp_next.result_first  = cells[idx_a];
    rsp_next.result_second = cells[idx_b];
    rsp_next.filler_used   = fill2;
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= req_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  // Pipeline payload; loaded only when a stage takes a valid item.
  always_ff @(posedge clk) begin
    if (rdy1 && req_valid) begin
      op1     <= req.operation;
      fill1   <= filler;
      hits_a1 <= hits_a;
      hits_b1 <= hits_b;
    end
    if (rdy2 && v1) begin
      op2    <= op1;
      fill2  <= fill1;
      pos_a2 <= pfc_pkg::lowest_hit(hits_a1);
      pos_b2 <= pfc_pkg::lowest_hit(hits_b1);
    end
    if (rdy3 && v2) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTH
  // Positions out of the encoder always lie inside the grid.
  a_pos_in_grid: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (pos_a2.row < pfc_pkg::GRID_SIDE) && (pos_a2.col < pfc_pkg::GRID_SIDE) &&
           (pos_b2.row < pfc_pkg::GRID_SIDE) && (pos_b2.col < pfc_pkg::GRID_SIDE))
    else $error("grid position out of range");

  // The filler is only ever inserted on encryption.
  a_filler_encrypt: assert property (@(posedge clk) disable iff (rst)
    (v2 && fill2) |-> (op2 == pfc_pkg::OP_ENCRYPT))
    else $error("filler flagged on a decrypt transaction");

  // An empty first stage never stalls the request side.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> !req_stall)
    else $error("request stalled with an empty first stage");

  // A held response is not dropped by the pipeline behind it.
  a_rsp_kept: assert property (@(posedge clk) disable iff (rst)
    (v3 && rsp_stall && v2) |=> (v3 && v2))
    else $error("pipeline item lost under stall");
`endif

endmodule

// ===== tb/playfair_digraph_cipher_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the Playfair digraph cipher: random and directed letter pairs
// against several key squares. Depends on pfc_pkg and the playfair_digraph_cipher RTL only.
module playfair_digraph_cipher_tb;
  import pfc_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 6;
  // Three pipeline stages plus margin; used before key writes and at the end.
  localparam int SETTLE_CYCLES = 8;
  // Around 1500 transactions in all; the limit leaves ample room for them.
  localparam int LIMIT_CYCLES = 200000;
  localparam int HIGH_BITS    = REG_W - LETTER_W;

  // The write port has a fourth index that maps to no register; writing it must do nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum int {
    SQ_ALPHABET,      // a to z without j, row major
    SQ_SHUFFLED,      // a random arrangement of the same 25 letters
    SQ_ALL_ONES,      // every cell 31, every register bit set
    SQ_RANDOM_CELLS,  // any five-bit value per cell: duplicates, gaps, values above z
    SQ_CLEAR          // every cell zero
  } square_kind_t;

  // Directed pairs, all meant for the alphabetical square:
  //   a b c d e / f g h i k / l m n o p / q r s t u / v w x y z
  localparam int NUM_DIRECTED = 20;
  localparam pair_req_t DIRECTED_PAIRS [NUM_DIRECTED] = '{
    '{OP_ENCRYPT, 5'd0,  5'd4 },   // same row, wraps to the row start
    '{OP_DECRYPT, 5'd0,  5'd4 },   // same row backwards, wraps the other way
    '{OP_ENCRYPT, 5'd0,  5'd21},   // same column, wraps to the top
    '{OP_DECRYPT, 5'd0,  5'd21},   // same column upwards
    '{OP_ENCRYPT, 5'd1,  5'd25},   // rectangle corners
    '{OP_DECRYPT, 5'd1,  5'd25},
    '{OP_ENCRYPT, 5'd11, 5'd11},   // doubled pair gets the filler
    '{OP_DECRYPT, 5'd11, 5'd11},   // no filler on decrypt
    '{OP_ENCRYPT, LETTER_J, 5'd10},
    '{OP_ENCRYPT, LETTER_I, LETTER_J},   // i and j count as a doubled pair
    '{OP_DECRYPT, LETTER_J, LETTER_J},
    '{OP_ENCRYPT, LETTER_X, LETTER_X},   // filler is x itself
    '{OP_DECRYPT, LETTER_X, LETTER_X},
    '{OP_ENCRYPT, 5'd26, 5'd31},   // letters held by no cell fall back to the top left
    '{OP_ENCRYPT, 5'd31, 5'd0 },
    '{OP_DECRYPT, 5'd30, 5'd25},
    '{OP_ENCRYPT, 5'd31, 5'd31},
    '{OP_ENCRYPT, 5'd0,  5'd25},
    '{OP_DECRYPT, 5'd25, 5'd0 },
    '{OP_DECRYPT, 5'd31, 5'd31}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [1:0]           cfg_index = REG_CELLS_LOW;
  logic [REG_W-1:0]     cfg_data = '0;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  pair_req_t            req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  pair_rsp_t            rsp;

  // Local copy of the key square, updated whenever the registers are written.
  logic [REG_W-1:0]     square_low = '0;
  logic [REG_W-1:0]     square_mid = '0;
  logic [LETTER_W-1:0]  square_last = '0;

  // Pairs waiting to be offered, and the transformed pairs still to come back.
  pair_req_t            outgoing_pairs [$];
  pair_rsp_t            enciphered_pairs [$];

  int unsigned          send_gap_pct = 0;
  int unsigned          recv_stall_pct = 0;
  int unsigned          fail_count = 0;

  playfair_digraph_cipher u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Letter held by a cell of the local square, cells counted row major.
  function automatic logic [LETTER_W-1:0] square_cell(input int idx);
    if (idx < LOW_CELLS) begin
      return square_low[LETTER_W * idx +: LETTER_W];
    end else if (idx < 2 * LOW_CELLS) begin
      return square_mid[LETTER_W * (idx - LOW_CELLS) +: LETTER_W];
    end
    return square_last;
  endfunction

  // The first cell holding the letter wins; a letter that no cell holds sits at cell 0.
  function automatic int find_letter(input logic [LETTER_W-1:0] letter);
    for (int idx = 0; idx < GRID_CELLS; idx++) begin
      if (square_cell(idx) == letter) begin
        return idx;
      end
    end
    return 0;
  endfunction

  // Applies the Playfair rules to one pair against the current local square.
  function automatic pair_rsp_t playfair_transform(input pair_req_t pair);
    pair_rsp_t           out;
    logic [LETTER_W-1:0] first, second;
    int                  pos_a, pos_b, row_a, col_a, row_b, col_b, shift;
    first  = (pair.letter_first == LETTER_J) ? LETTER_I : pair.letter_first;
    second = (pair.letter_second == LETTER_J) ? LETTER_I : pair.letter_second;
    out.filler_used = 1'b0;
    if (pair.operation == OP_ENCRYPT && first == second) begin
      second = LETTER_X;
      out.filler_used = 1'b1;
    end
    pos_a = find_letter(first);
    pos_b = find_letter(second);
    row_a = pos_a / GRID_SIDE;
    col_a = pos_a % GRID_SIDE;
    row_b = pos_b / GRID_SIDE;
    col_b = pos_b % GRID_SIDE;
    // Moving back one place is the same as moving forward four with wrap-around.
    shift = (pair.operation == OP_DECRYPT) ? GRID_SIDE - 1 : 1;
    if (row_a == row_b) begin
      out.result_first  = square_cell(row_a * GRID_SIDE + (col_a + shift) % GRID_SIDE);
      out.result_second = square_cell(row_b * GRID_SIDE + (col_b + shift) % GRID_SIDE);
    end else if (col_a == col_b) begin
      out.result_first  = square_cell(((row_a + shift) % GRID_SIDE) * GRID_SIDE + col_a);
      out.result_second = square_cell(((row_b + shift) % GRID_SIDE) * GRID_SIDE + col_b);
    end else begin
      out.result_first  = square_cell(row_a * GRID_SIDE + col_b);
      out.result_second = square_cell(row_b * GRID_SIDE + col_a);
    end
    return out;
  endfunction

  // Mostly real letters, with the occasional value that no alphabet letter has.
  function automatic logic [LETTER_W-1:0] random_letter();
    if ($urandom_range(9) == 0) begin
      return LETTER_W'($urandom_range(31));
    end
    return LETTER_W'($urandom_range(25));
  endfunction

  // Request driver. A pair stays on the bus until it has been accepted; when a transaction
  // completes, the model of the cipher is run on it and the answer queued for the monitor.
  // Gaps are only inserted between transactions, never under a waiting pair.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        enciphered_pairs.push_back(playfair_transform(req));
      end
      if (!req_valid || !req_stall) begin
        if (outgoing_pairs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          req       <= outgoing_pairs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor. Every accepted response is matched against the oldest waiting
  // expectation, field by field; the stall towards the block is redrawn every cycle.
  always @(posedge clk) begin
    pair_rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (enciphered_pairs.size() == 0) begin
          $error("response transaction arrived with none outstanding");
          fail_count++;
        end else begin
          want = enciphered_pairs.pop_front();
          if (rsp.result_first !== want.result_first) begin
            $error("result_first: expected %0d, actual %0d", want.result_first,
                   rsp.result_first);
            fail_count++;
          end
          if (rsp.result_second !== want.result_second) begin
            $error("result_second: expected %0d, actual %0d", want.result_second,
                   rsp.result_second);
            fail_count++;
          end
          if (rsp.filler_used !== want.filler_used) begin
            $error("filler_used: expected %0d, actual %0d", want.filler_used,
                   rsp.filler_used);
            fail_count++;
          end
        end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // One phase: load a key square while the block is idle, set the idling rates, queue the
  // pairs, then wait until every response has been seen and the pipeline has emptied.
  task automatic run_phase(input square_kind_t kind, input int unsigned num_pairs,
                           input int unsigned gap_pct, input int unsigned stall_pct);
    logic [LETTER_W-1:0] cells [GRID_CELLS];
    logic [REG_W-1:0]    low_word, mid_word, last_word;
    logic [LETTER_W-1:0] held;
    int unsigned         pick, letter;
    pair_req_t           pair;
    letter = 0;
    for (int i = 0; i < GRID_CELLS; i++) begin
      if (letter == LETTER_J) begin
        letter++;
      end
      cells[i] = LETTER_W'(letter);
      letter++;
    end
    case (kind)
      SQ_SHUFFLED: begin
        for (int i = GRID_CELLS - 1; i > 0; i--) begin
          pick        = $urandom_range(i);
          held        = cells[i];
          cells[i]    = cells[pick];
          cells[pick] = held;
        end
      end
      SQ_ALL_ONES: begin
        foreach (cells[i]) cells[i] = '1;
      end
      SQ_RANDOM_CELLS: begin
        foreach (cells[i]) cells[i] = LETTER_W'($urandom_range(31));
      end
      SQ_CLEAR: begin
        foreach (cells[i]) cells[i] = '0;
      end
      default: begin
      end
    endcase
    low_word = '0;
    mid_word = '0;
    for (int i = 0; i < LOW_CELLS; i++) begin
      low_word[LETTER_W * i +: LETTER_W] = cells[i];
      mid_word[LETTER_W * i +: LETTER_W] = cells[LOW_CELLS + i];
    end
    last_word = REG_W'(cells[GRID_CELLS - 1]);
    // The last register only keeps its low five bits, so the rest is sometimes filled.
    if (kind == SQ_ALL_ONES) begin
      last_word = '1;
    end else if (kind == SQ_RANDOM_CELLS) begin
      last_word[REG_W-1:LETTER_W] = HIGH_BITS'({$urandom(), $urandom()});
    end

    // Back-to-back writes; the enable only drops after the last one.
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_CELLS_LOW;
    cfg_data  <= low_word;
    @(posedge clk);
    cfg_index <= REG_CELLS_MID;
    cfg_data  <= mid_word;
    @(posedge clk);
    cfg_index <= REG_CELL_LAST;
    cfg_data  <= last_word;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= REG_W'({$urandom(), $urandom()});
    @(posedge clk);
    cfg_write      <= 1'b0;
    send_gap_pct   <= gap_pct;
    recv_stall_pct <= stall_pct;
    square_low  = low_word;
    square_mid  = mid_word;
    square_last = last_word[LETTER_W-1:0];

    // Filling the queue away from the rising edge keeps clear of the driver.
    @(negedge clk);
    if (kind == SQ_ALPHABET) begin
      foreach (DIRECTED_PAIRS[i]) outgoing_pairs.push_back(DIRECTED_PAIRS[i]);
    end
    for (int n = 0; n < num_pairs; n++) begin
      pair.operation    = ($urandom_range(1) == 0) ? OP_ENCRYPT : OP_DECRYPT;
      pair.letter_first = random_letter();
      // Doubled pairs are rare by chance, so a share of them is forced.
      pair.letter_second = ($urandom_range(6) == 0) ? pair.letter_first : random_letter();
      outgoing_pairs.push_back(pair);
    end

    while (outgoing_pairs.size() != 0 || req_valid || enciphered_pairs.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Sender idles more than a third of the time, receiver stalls more often than not.
    run_phase(SQ_ALPHABET,     0,   36, 61);
    run_phase(SQ_SHUFFLED,     450, 36, 61);
    run_phase(SQ_ALL_ONES,     40,  36, 61);
    // The same rates swapped between the two sides.
    run_phase(SQ_SHUFFLED,     450, 61, 36);
    run_phase(SQ_RANDOM_CELLS, 80,  61, 36);
    // Full rate on both sides.
    run_phase(SQ_CLEAR,        40,  0,  0);
    run_phase(SQ_RANDOM_CELLS, 40,  0,  0);
    run_phase(SQ_SHUFFLED,     400, 0,  0);

    if (fail_count == 0) begin
      $display("PASS playfair_digraph_cipher");
    end else begin
      $display("FAIL playfair_digraph_cipher");
    end
    $finish;
  end

  // Guards against a hung handshake or lost responses.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAIL playfair_digraph_cipher");
    $finish;
  end

endmodule
